// ----- rtl/core/cttt_pkg.sv -----
// Shared operation codes, error codes and controller/datapath handshake types.
package cttt_pkg;

  localparam int OP_W = 3;
  localparam int HANDLE_W = 8;
  localparam int TIME_W = 32;
  localparam int SLOT_IN_W = 4;
  localparam int SLOT_OUT_W = 5;
  localparam int ERR_W = 2;
  localparam int COUNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_INVALID = 2'd2;

  localparam logic [TIME_W-1:0] UNDERFLOW_LIMIT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic load;
    logic op_exec;
    logic tick_step;
    logic disp_step;
    logic emit_final;
  } cttt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            tick_done;
    logic            disp_done;
    logic            disp_hit;
    logic            out_free;
  } cttt_status_t;

endpackage

// ----- rtl/core/cttt_if.sv -----
// Valid/ready channel interfaces for the task table request and result streams.
interface cttt_req_if;
  logic                           valid;
  logic                           ready;
  logic [cttt_pkg::OP_W-1:0]      operation;
  logic [cttt_pkg::HANDLE_W-1:0]  task_handle;
  logic [cttt_pkg::TIME_W-1:0]    first_delay;
  logic [cttt_pkg::TIME_W-1:0]    repeat_period;
  logic [cttt_pkg::SLOT_IN_W-1:0] slot_index;
  modport source (output valid, operation, task_handle, first_delay, repeat_period,
                  slot_index, input ready);
  modport sink (input valid, operation, task_handle, first_delay, repeat_period,
                slot_index, output ready);
endinterface

interface cttt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cttt_pkg::SLOT_OUT_W-1:0]  slot_result;
  logic [cttt_pkg::ERR_W-1:0]       error_code;
  logic [cttt_pkg::HANDLE_W-1:0]    run_handle;
  logic                             run_valid;
  logic [cttt_pkg::COUNT_OUT_W-1:0] task_count;
  logic                             last;
  modport source (output valid, slot_result, error_code, run_handle, run_valid,
                  task_count, last, input ready);
  modport sink (input valid, slot_result, error_code, run_handle, run_valid,
                task_count, last, output ready);
endinterface

// ----- rtl/core/cttt_ctrl.sv -----
// Controller state machine that sequences each operation over the datapath.
module cttt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  cttt_pkg::cttt_status_t status,
  output cttt_pkg::cttt_cmd_t    cmd
);
  import cttt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OP    = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_DISP  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = S_OP;
        end
      end
      S_OP: begin
        case (status.op)
          OP_TICK: state_next = S_TICK;
          OP_DISPATCH: state_next = S_DISP;
          default: begin
            cmd.op_exec = 1'b1;
            state_next = S_FINAL;
          end
        endcase
      end
      S_TICK: begin
        if (status.tick_done) begin
          state_next = S_FINAL;
        end else begin
          cmd.tick_step = 1'b1;
        end
      end
      S_DISP: begin
        if (status.disp_done) begin
          state_next = S_FINAL;
        end else if (!status.disp_hit || status.out_free) begin
          cmd.disp_step = 1'b1;
        end
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/cttt_datapath.sv -----
// Task table storage, per-entry tick/dispatch logic and the result register.
module cttt_datapath #(
  parameter int MAX_TASKS = 16,
  parameter int PENDING_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  cttt_req_if.sink               req,
  cttt_rsp_if.source             rsp,
  input  cttt_pkg::cttt_cmd_t    cmd,
  output cttt_pkg::cttt_status_t status
);
  import cttt_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [PENDING_WIDTH-1:0] PEND_MAX = '1;

  logic [HANDLE_W-1:0]      handle_store  [MAX_TASKS];
  logic [TIME_W-1:0]        delay_store   [MAX_TASKS];
  logic [TIME_W-1:0]        period_store  [MAX_TASKS];
  logic [PENDING_WIDTH-1:0] pending_store [MAX_TASKS];
  logic                     one_shot_store[MAX_TASKS];
  logic [CW-1:0]            entry_count;
  logic [ERR_W-1:0]         error_reg;

  // Latched request fields.
  logic [OP_W-1:0]      op;
  logic [HANDLE_W-1:0]  handle;
  logic [TIME_W-1:0]    delay;
  logic [TIME_W-1:0]    period;
  logic [SLOT_IN_W-1:0] slot;
  logic [CW-1:0]        ptr;
  logic [SLOT_OUT_W-1:0] res_slot;

  logic [IW-1:0] idx;
  logic          walk_done;
  logic [TIME_W-1:0] cur_delay;
  logic [TIME_W-1:0] cur_period;
  logic [PENDING_WIDTH-1:0] cur_pend;
  logic          cur_one_shot;
  logic          out_free;

  assign idx = ptr[IW-1:0];
  assign walk_done = (32'(ptr) >= 32'(entry_count)) || (32'(ptr) >= MAX_TASKS);
  assign cur_delay = delay_store[idx];
  assign cur_period = period_store[idx];
  assign cur_pend = pending_store[idx];
  assign cur_one_shot = one_shot_store[idx];
  assign out_free = !rsp.valid || rsp.ready;

  assign status.op = op;
  assign status.tick_done = walk_done;
  assign status.disp_done = walk_done;
  assign status.disp_hit = (cur_pend != '0);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    logic [TIME_W-1:0] nd;
    logic              due;
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        handle_store[i] <= '0;
        delay_store[i] <= '0;
        period_store[i] <= '0;
        pending_store[i] <= '0;
        one_shot_store[i] <= 1'b0;
      end
      entry_count <= '0;
      error_reg <= ERR_NONE;
      rsp.valid <= 1'b0;
      ptr <= '0;
      op <= OP_CLEAR;
    end else begin
      if (rsp.valid && rsp.ready && !cmd.emit_final && !(cmd.disp_step && cur_pend != '0)) begin
        rsp.valid <= 1'b0;
      end

      if (cmd.load) begin
        op <= req.operation;
        handle <= req.task_handle;
        delay <= req.first_delay;
        period <= req.repeat_period;
        slot <= req.slot_index;
        ptr <= '0;
        res_slot <= '0;
      end

      if (cmd.op_exec) begin
        case (op)
          OP_CLEAR: begin
            for (int i = 0; i < MAX_TASKS; i++) begin
              handle_store[i] <= '0;
              delay_store[i] <= '0;
              period_store[i] <= '0;
              pending_store[i] <= '0;
              one_shot_store[i] <= 1'b0;
            end
            entry_count <= '0;
            error_reg <= ERR_NONE;
          end
          OP_ADD: begin
            if (32'(entry_count) >= MAX_TASKS) begin
              error_reg <= ERR_FULL;
              res_slot <= SLOT_OUT_W'(MAX_TASKS);
            end else if (handle == '0) begin
              error_reg <= ERR_INVALID;
              res_slot <= SLOT_OUT_W'(MAX_TASKS);
            end else begin
              handle_store[entry_count[IW-1:0]] <= handle;
              delay_store[entry_count[IW-1:0]] <= delay;
              period_store[entry_count[IW-1:0]] <= period;
              pending_store[entry_count[IW-1:0]] <= '0;
              one_shot_store[entry_count[IW-1:0]] <= (period == '0);
              entry_count <= entry_count + 1'b1;
              res_slot <= SLOT_OUT_W'(entry_count);
            end
          end
          OP_DELETE: begin
            if ((32'(slot) >= 32'(entry_count)) || (32'(slot) >= MAX_TASKS)) begin
              error_reg <= ERR_INVALID;
              res_slot <= SLOT_OUT_W'(MAX_TASKS);
            end else begin
              // Entries past the fill point are kept zero, so a plain shift works.
              for (int i = 0; i < MAX_TASKS; i++) begin
                if (i >= 32'(slot)) begin
                  if (i + 1 < MAX_TASKS) begin
                    handle_store[i] <= handle_store[i+1];
                    delay_store[i] <= delay_store[i+1];
                    period_store[i] <= period_store[i+1];
                    pending_store[i] <= pending_store[i+1];
                    one_shot_store[i] <= one_shot_store[i+1];
                  end else begin
                    handle_store[i] <= '0;
                    delay_store[i] <= '0;
                    period_store[i] <= '0;
                    pending_store[i] <= '0;
                    one_shot_store[i] <= 1'b0;
                  end
                end
              end
              entry_count <= entry_count - 1'b1;
              res_slot <= SLOT_OUT_W'(slot);
            end
          end
          default: ;
        endcase
      end

      if (cmd.tick_step) begin
        nd = cur_delay;
        due = 1'b0;
        if (cur_delay > UNDERFLOW_LIMIT) begin
          nd = '0;
          error_reg <= ERR_INVALID;
          due = 1'b1;
        end else if (cur_delay != '0) begin
          nd = cur_delay - 1'b1;
          due = (nd == '0);
        end else begin
          due = 1'b1;
        end
        if (due) begin
          if (cur_pend != PEND_MAX) begin
            pending_store[idx] <= cur_pend + 1'b1;
          end
          if (cur_period != '0) begin
            nd = cur_period;
          end
        end
        delay_store[idx] <= nd;
        ptr <= ptr + 1'b1;
      end

      if (cmd.disp_step) begin
        if (cur_pend != '0) begin
          rsp.valid <= 1'b1;
          rsp.slot_result <= SLOT_OUT_W'(ptr);
          rsp.error_code <= error_reg;
          rsp.run_handle <= handle_store[idx];
          rsp.run_valid <= 1'b1;
          rsp.last <= 1'b0;
          if (cur_one_shot) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
              if (i >= 32'(ptr)) begin
                if (i + 1 < MAX_TASKS) begin
                  handle_store[i] <= handle_store[i+1];
                  delay_store[i] <= delay_store[i+1];
                  period_store[i] <= period_store[i+1];
                  pending_store[i] <= pending_store[i+1];
                  one_shot_store[i] <= one_shot_store[i+1];
                end else begin
                  handle_store[i] <= '0;
                  delay_store[i] <= '0;
                  period_store[i] <= '0;
                  pending_store[i] <= '0;
                  one_shot_store[i] <= 1'b0;
                end
              end
            end
            entry_count <= entry_count - 1'b1;
            rsp.task_count <= COUNT_OUT_W'(entry_count - 1'b1);
          end else begin
            pending_store[idx] <= cur_pend - 1'b1;
            rsp.task_count <= COUNT_OUT_W'(entry_count);
            ptr <= ptr + 1'b1;
          end
        end else begin
          ptr <= ptr + 1'b1;
        end
      end

      if (cmd.emit_final) begin
        rsp.valid <= 1'b1;
        rsp.slot_result <= res_slot;
        rsp.error_code <= error_reg;
        rsp.run_handle <= '0;
        rsp.run_valid <= 1'b0;
        rsp.task_count <= COUNT_OUT_W'(entry_count);
        rsp.last <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/cooperative_task_timer_table_top.sv -----
// Top level of the cooperative task timer table: controller plus datapath.
//
// Usage: requests arrive on the req channel (operation, task_handle, first_delay,
// repeat_period, slot_index); each transfer performs one clear, add, tick,
// dispatch or delete on a packed table of MAX_TASKS timed tasks. Results leave
// on the rsp channel. Clear, add, tick, delete and unused codes give one result
// with last set. Dispatch gives one run result per task with a pending run, in
// slot order, then a closing result with last set.
// Sequencing: one request is worked on at a time. Clear, add and delete pass
// through the load, operation and final states. Tick walks the occupied
// slots one per cycle, then emits its result. Dispatch walks the slots one per
// cycle while the output register is free or the slot has no pending run, and
// re-examines a slot after a one-shot removal. The walk reads one slot at a
// time, indexed by the walk pointer.
// The result sits in an output register; while the receiver stalls, the block
// holds it and pauses at the next result it needs to emit. The next request is
// taken as soon as the previous one's final result is in the output register.
// Reset (rst, synchronous) empties the table, clears the sticky error and the
// output valid.
module cooperative_task_timer_table_top #(
  parameter int MAX_TASKS = 16,
  parameter int PENDING_WIDTH = 8
) (
  input logic        clk,
  input logic        rst,
  cttt_req_if.sink   req,
  cttt_rsp_if.source rsp
);
  import cttt_pkg::*;

  cttt_cmd_t    cmd;
  cttt_status_t status;

  // The controller owns the request handshake; the datapath owns the result.
  cttt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cttt_datapath #(
    .MAX_TASKS     (MAX_TASKS),
    .PENDING_WIDTH (PENDING_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cmd    (cmd),
    .status (status)
  );

endmodule
